>>> rtl/tct_pkg.sv
// ----------------------------------------------------------------------------
// Touch contact tracker package
// Shared types and codes for the contact tracker front end, back end and top.
// ----------------------------------------------------------------------------
package tct_pkg;

	typedef enum logic [2:0] {
		OP_BEGIN       = 3'd0,
		OP_MOVE        = 3'd1,
		OP_END         = 3'd2,
		OP_CANCEL      = 3'd3,
		OP_RESET       = 3'd4,
		OP_LOOKUP      = 3'd5,
		OP_READ_HIST   = 3'd6,
		OP_READ_ACTIVE = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_RANGE     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		KIND_BEGIN = 2'd0,
		KIND_END   = 2'd1,
		KIND_MOVE  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ACT_INSERT    = 4'd0,
		ACT_MOVE      = 4'd1,
		ACT_ERASE     = 4'd2,
		ACT_UPSERT    = 4'd3,
		ACT_NOP       = 4'd4,
		ACT_CLR_HIST  = 4'd5,
		ACT_CLR_TABLE = 4'd6,
		ACT_LOOKUP    = 4'd7,
		ACT_RD_HIST   = 4'd8,
		ACT_RD_ACTIVE = 4'd9
	} act_t;

	typedef struct packed {
		act_t               act;
		logic               log_en;
		kind_t              kind;
		logic [31:0]        id;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [4:0]         idx;
	} cmd_t;

	typedef struct packed {
		status_t            status;
		kind_t              event_kind;
		logic [31:0]        out_id;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic [4:0]         active_count;
		logic [5:0]         history_count;
	} result_t;

	localparam int IN_W   = 104;
	localparam int OUT_W  = 112;
	localparam int HIST_W = 98;

endpackage

>>> rtl/tct_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/tct_front.sv
// ----------------------------------------------------------------------------
// Contact tracker front end
// Accepts input transfers, decodes them into commands and queues up to two of them.
// ----------------------------------------------------------------------------
module tct_front import tct_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            immediate_mode,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [IN_W-1:0] s_axis_tdata,
	output cmd_t            cmd,
	output logic            cmd_valid,
	input  logic            cmd_pop
);

	cmd_t       dec;
	cmd_t       q_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	op_t        op;

	assign op = op_t'(s_axis_tdata[2:0]);

	always_comb begin
		dec.id     = s_axis_tdata[34:3];
		dec.x      = s_axis_tdata[66:35];
		dec.y      = s_axis_tdata[98:67];
		dec.idx    = s_axis_tdata[103:99];
		dec.log_en = 1'b0;
		dec.kind   = KIND_BEGIN;
		dec.act    = ACT_NOP;
		unique case (op)
			OP_BEGIN: begin
				if (immediate_mode) begin
					dec.act = ACT_UPSERT;
				end else begin
					dec.act    = ACT_INSERT;
					dec.log_en = 1'b1;
				end
			end
			OP_MOVE: begin
				if (immediate_mode) begin
					dec.act = ACT_UPSERT;
				end else begin
					dec.act    = ACT_MOVE;
					dec.log_en = 1'b1;
					dec.kind   = KIND_MOVE;
				end
			end
			OP_END, OP_CANCEL: begin
				if (!immediate_mode) begin
					dec.act    = ACT_ERASE;
					dec.log_en = 1'b1;
					dec.kind   = KIND_END;
				end
			end
			OP_RESET: begin
				dec.act = immediate_mode ? ACT_CLR_TABLE : ACT_CLR_HIST;
			end
			OP_LOOKUP:      dec.act = ACT_LOOKUP;
			OP_READ_HIST:   dec.act = ACT_RD_HIST;
			OP_READ_ACTIVE: dec.act = ACT_RD_ACTIVE;
		endcase
	end

	assign s_axis_tready = (cnt_q != 2'd2);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign cmd_valid     = (cnt_q != 2'd0);
	assign cmd           = q_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (cmd_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= dec;
		end
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("command queue count out of range");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cnt_q != 2'd0)
		else $error("command popped from an empty queue");
`endif

endmodule

>>> rtl/tct_back.sv
// ----------------------------------------------------------------------------
// Contact tracker back end
// Executes queued commands on the contact table and the history RAM.
// ----------------------------------------------------------------------------
module tct_back import tct_pkg::*; #(
	parameter int MAX_CONTACTS  = 16,
	parameter int HISTORY_DEPTH = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  logic    cmd_valid,
	output logic    cmd_pop,
	output result_t res,
	output logic    res_valid,
	input  logic    res_ready
);

	localparam int CW  = $clog2(MAX_CONTACTS + 1);
	localparam int PW  = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
	localparam int CSW = (CW > 5) ? CW : 5;
	localparam int HC  = $clog2(HISTORY_DEPTH + 1);
	localparam int HA  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int HSW = ((HC > 5) ? HC : 5) + 1;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t             state_q;
	logic [31:0]        ids_q [MAX_CONTACTS];
	logic signed [31:0] px_q  [MAX_CONTACTS];
	logic signed [31:0] py_q  [MAX_CONTACTS];
	logic [31:0]        nxt_id [MAX_CONTACTS];
	logic signed [31:0] nxt_x  [MAX_CONTACTS];
	logic signed [31:0] nxt_y  [MAX_CONTACTS];
	logic [CW-1:0]      ct_total_q;
	logic [HC-1:0]      hist_total_q;
	logic [HA-1:0]      head_q;
	cmd_t               cmd_s1;
	logic               hit_s1;
	logic [PW-1:0]      pos_s1;
	result_t            out_q;
	logic               out_valid_q;

	logic               hit;
	logic [PW-1:0]      pos;
	logic [HSW-1:0]     rsum;
	logic [HSW-1:0]     wsum;
	logic [HA-1:0]      raddr;
	logic [HA-1:0]      waddr;
	logic [HIST_W-1:0]  rdata;
	logic               commit;
	logic [PW-1:0]      rd_pos;
	logic               room;
	logic               idx_ok_c;
	logic               idx_ok_h;
	logic               hist_full;
	logic               do_ins;
	logic               do_upd;
	logic               do_erase;
	logic               do_log;
	logic               ct_clr;
	logic               hist_clr;
	logic [CW-1:0]      ct_next;
	logic [HC-1:0]      hist_next;
	logic [HA-1:0]      head_next;
	result_t            r;

	always_comb begin
		hit = 1'b0;
		pos = '0;
		for (int i = MAX_CONTACTS - 1; i >= 0; i--) begin
			if (ids_q[i] == cmd.id && CW'(i) < ct_total_q) begin
				hit = 1'b1;
				pos = PW'(i);
			end
		end
	end

	assign rsum  = HSW'(head_q) + HSW'(cmd.idx);
	assign raddr = (rsum >= HSW'(HISTORY_DEPTH)) ? HA'(rsum - HSW'(HISTORY_DEPTH)) : HA'(rsum);
	assign wsum  = HSW'(head_q) + HSW'(hist_total_q);
	assign waddr = (wsum >= HSW'(HISTORY_DEPTH)) ? HA'(wsum - HSW'(HISTORY_DEPTH)) : HA'(wsum);

	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;
	assign commit  = (state_q == S_EXEC) && (!out_valid_q || res_ready);

	tct_ram #(
		.WIDTH(HIST_W),
		.DEPTH(HISTORY_DEPTH)
	) u_hist_ram (
		.clk  (clk),
		.we   (commit && do_log),
		.waddr(waddr),
		.wdata({cmd_s1.kind, cmd_s1.id, cmd_s1.x, cmd_s1.y}),
		.re   (cmd_pop),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_pos    = (cmd_s1.act == ACT_LOOKUP) ? pos_s1 : PW'(cmd_s1.idx);
	assign room      = ct_total_q < CW'(MAX_CONTACTS);
	assign idx_ok_c  = CSW'(cmd_s1.idx) < CSW'(ct_total_q);
	assign idx_ok_h  = HSW'(cmd_s1.idx) < HSW'(hist_total_q);
	assign hist_full = hist_total_q == HC'(HISTORY_DEPTH);

	always_comb begin
		r          = '0;
		r.status   = STAT_OK;
		r.event_kind = KIND_BEGIN;
		do_ins     = 1'b0;
		do_upd     = 1'b0;
		do_erase   = 1'b0;
		do_log     = 1'b0;
		ct_clr     = 1'b0;
		hist_clr   = 1'b0;
		unique case (cmd_s1.act)
			ACT_INSERT, ACT_MOVE, ACT_ERASE, ACT_UPSERT, ACT_NOP: begin
				r.event_kind = cmd_s1.kind;
				r.out_id     = cmd_s1.id;
				r.out_x      = cmd_s1.x;
				r.out_y      = cmd_s1.y;
				do_log       = cmd_s1.log_en;
				if (cmd_s1.act == ACT_INSERT) begin
					if (room) begin
						do_ins = 1'b1;
					end else begin
						r.status = STAT_FULL;
					end
				end else if (cmd_s1.act == ACT_MOVE || cmd_s1.act == ACT_ERASE) begin
					if (!hit_s1) begin
						r.status = STAT_NOT_FOUND;
					end else if (cmd_s1.act == ACT_MOVE) begin
						do_upd = 1'b1;
					end else begin
						do_erase = 1'b1;
					end
				end else if (cmd_s1.act == ACT_UPSERT) begin
					if (hit_s1) begin
						do_upd = 1'b1;
					end else if (room) begin
						do_ins = 1'b1;
					end else begin
						r.status = STAT_FULL;
					end
				end
			end
			ACT_CLR_HIST:  hist_clr = 1'b1;
			ACT_CLR_TABLE: ct_clr = 1'b1;
			ACT_LOOKUP: begin
				if (hit_s1) begin
					r.out_id = ids_q[rd_pos];
					r.out_x  = px_q[rd_pos];
					r.out_y  = py_q[rd_pos];
				end else begin
					r.status = STAT_NOT_FOUND;
				end
			end
			ACT_RD_HIST: begin
				if (idx_ok_h) begin
					r.event_kind = kind_t'(rdata[97:96]);
					r.out_id     = rdata[95:64];
					r.out_x      = rdata[63:32];
					r.out_y      = rdata[31:0];
				end else begin
					r.status = STAT_RANGE;
				end
			end
			ACT_RD_ACTIVE: begin
				if (idx_ok_c) begin
					r.out_id = ids_q[rd_pos];
					r.out_x  = px_q[rd_pos];
					r.out_y  = py_q[rd_pos];
				end else begin
					r.status = STAT_RANGE;
				end
			end
			default: r.status = STAT_OK;
		endcase

		ct_next = ct_total_q;
		if (ct_clr) begin
			ct_next = '0;
		end else if (do_ins) begin
			ct_next = ct_total_q + CW'(1);
		end else if (do_erase) begin
			ct_next = ct_total_q - CW'(1);
		end

		hist_next = hist_total_q;
		head_next = head_q;
		if (hist_clr) begin
			hist_next = '0;
		end else if (do_log) begin
			if (hist_full) begin
				head_next = (head_q == HA'(HISTORY_DEPTH - 1)) ? '0 : head_q + HA'(1);
			end else begin
				hist_next = hist_total_q + HC'(1);
			end
		end

		r.active_count  = 5'(ct_next);
		r.history_count = 6'(hist_next);
	end

	for (genvar g = 0; g < MAX_CONTACTS; g++) begin : g_entry
		if (g < MAX_CONTACTS - 1) begin : g_shift
			assign nxt_id[g] = ids_q[g + 1];
			assign nxt_x[g]  = px_q[g + 1];
			assign nxt_y[g]  = py_q[g + 1];
		end else begin : g_last
			assign nxt_id[g] = ids_q[g];
			assign nxt_x[g]  = px_q[g];
			assign nxt_y[g]  = py_q[g];
		end

		always_ff @(posedge clk) begin
			if (commit) begin
				if (do_ins && CW'(g) == ct_total_q) begin
					ids_q[g] <= cmd_s1.id;
					px_q[g]  <= cmd_s1.x;
					py_q[g]  <= cmd_s1.y;
				end else if (do_upd && PW'(g) == pos_s1) begin
					px_q[g] <= cmd_s1.x;
					py_q[g] <= cmd_s1.y;
				end else if (do_erase && PW'(g) >= pos_s1) begin
					ids_q[g] <= nxt_id[g];
					px_q[g]  <= nxt_x[g];
					py_q[g]  <= nxt_y[g];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ct_total_q   <= '0;
			hist_total_q <= '0;
			head_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (commit) begin
				ct_total_q   <= ct_next;
				hist_total_q <= hist_next;
				head_q       <= head_next;
				out_valid_q  <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_s1 <= cmd;
			hit_s1 <= hit;
			pos_s1 <= pos;
		end
		if (commit) begin
			out_q <= r;
		end
	end

	assign res       = out_q;
	assign res_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_ct_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ct_total_q <= CW'(MAX_CONTACTS))
		else $error("active contact count exceeds the table size");
	a_hist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hist_total_q <= HC'(HISTORY_DEPTH))
		else $error("history count exceeds the history depth");
	a_pop_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> state_q == S_EXEC && !cmd_pop)
		else $error("command accepted while another one is executing");
`endif

endmodule

>>> rtl/touch_contact_tracker.sv
// ----------------------------------------------------------------------------
// Touch contact tracker
// Active contact table with an optional event history queue.
// ----------------------------------------------------------------------------
// Each input transfer is decoded by the front end into a two-entry command
// queue, so input transfers are taken while the back end works or while a
// result waits on the output. The back end works on one command at a time:
// in the idle state it takes the command, searches the contact table for the
// handle in parallel and reads the history RAM; in the execute state it
// updates the table and the history and loads the output register, and it
// waits there while the output still holds a result that was not taken.
// Every input transfer gives exactly one output transfer. The history store
// is a circular RAM and needs no clearing pass after reset. The mode register
// must be written only while no command is in flight.
module touch_contact_tracker import tct_pkg::*; #(
	parameter int MAX_CONTACTS  = 16,
	parameter int HISTORY_DEPTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// operation[2:0], touch_id[34:3], pos_x[66:35], pos_y[98:67],
	// entry_index[103:99]
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// status[1:0], event_kind[3:2], out_id[35:4], out_x[67:36],
	// out_y[99:68], active_count[104:100], history_count[110:105], zero[111]
	output logic [OUT_W-1:0] m_axis_tdata
);

	logic    mode_q;
	cmd_t    cmd;
	logic    cmd_valid;
	logic    cmd_pop;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	tct_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.immediate_mode(mode_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.cmd           (cmd),
		.cmd_valid     (cmd_valid),
		.cmd_pop       (cmd_pop)
	);

	tct_back #(
		.MAX_CONTACTS (MAX_CONTACTS),
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.res      (res),
		.res_valid(m_axis_tvalid),
		.res_ready(m_axis_tready)
	);

	assign m_axis_tdata = {1'b0, res.history_count, res.active_count, res.out_y,
		res.out_x, res.out_id, res.event_kind, res.status};

endmodule

>>> sim/touch_contact_tracker_tb.sv
// ----------------------------------------------------------------------------
// Touch contact tracker testbench
// Drives operation transfers into the tracker and compares every result
// transfer, field by field, with a contact table and event history kept
// here. A short table of directed rows covers empty reads, the coordinate
// extremes, duplicate handles and both modes. Random traffic follows, biased
// toward handles that are currently active. Both stream sides idle at random,
// the receiver twice holds off long enough to stall the input, and the mode
// register is switched between phases while the tracker is idle.
// ----------------------------------------------------------------------------
module touch_contact_tracker_tb;
	import tct_pkg::*;

	localparam int MAX_CONTACTS = 16;
	localparam int HIST_DEPTH   = 32;
	localparam int NUM_DIR      = 25;
	localparam int SEG_ITEMS    = 317;
	localparam int NUM_SEGS     = 6;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE       = 8;
	localparam int LIMIT_CYCLES = 200000;

	typedef struct packed {
		op_t                op;
		logic [31:0]        id;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [4:0]         idx;
	} touch_item_t;

	typedef struct {
		bit          mode;
		touch_item_t item;
		bit          typed;
		result_t     want;
	} dir_row_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              cfg_we        = 1'b0;
	logic              cfg_wdata     = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata  = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;

	logic [31:0]        trk_id [MAX_CONTACTS];
	logic signed [31:0] trk_x [MAX_CONTACTS];
	logic signed [31:0] trk_y [MAX_CONTACTS];
	int                 trk_total = 0;
	kind_t              hist_kind [HIST_DEPTH];
	logic [31:0]        hist_id [HIST_DEPTH];
	logic signed [31:0] hist_x [HIST_DEPTH];
	logic signed [31:0] hist_y [HIST_DEPTH];
	int                 hist_total = 0;
	bit                 imm_mode = 1'b0;

	result_t tracker_replies [$];
	result_t got_reply;
	result_t want_reply;
	int      bad_fields  = 0;
	int      reply_count = 0;
	int      send_idle   = 0;
	int      recv_idle   = 0;
	int      hold_req    = 0;
	int      hold_seen   = 0;
	int      hold_left   = 0;

	dir_row_t dir_rows [NUM_DIR] = '{
		'{1'b0, '{OP_READ_ACTIVE, 32'h0, 32'h0, 32'h0, 5'd0}, 1'b1,
			'{STAT_RANGE, KIND_BEGIN, 32'h0, 32'h0, 32'h0, 5'd0, 6'd0}},
		'{1'b0, '{OP_READ_HIST, 32'h0, 32'h0, 32'h0, 5'd31}, 1'b1,
			'{STAT_RANGE, KIND_BEGIN, 32'h0, 32'h0, 32'h0, 5'd0, 6'd0}},
		'{1'b0, '{OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 5'd0}, 1'b1,
			'{STAT_NOT_FOUND, KIND_BEGIN, 32'h0, 32'h0, 32'h0, 5'd0, 6'd0}},
		'{1'b0, '{OP_MOVE, 32'h5, 32'h7FFF_FFFF, 32'h8000_0000, 5'd0}, 1'b1,
			'{STAT_NOT_FOUND, KIND_MOVE, 32'h5, 32'h7FFF_FFFF, 32'h8000_0000,
			5'd0, 6'd1}},
		'{1'b0, '{OP_BEGIN, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 5'd0}, 1'b1,
			'{STAT_OK, KIND_BEGIN, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			5'd1, 6'd2}},
		'{1'b0, '{OP_BEGIN, 32'h0, 32'h0, 32'hFFFF_FFFF, 5'd31}, 1'b1,
			'{STAT_OK, KIND_BEGIN, 32'h0, 32'h0, 32'hFFFF_FFFF, 5'd2, 6'd3}},
		'{1'b0, '{OP_BEGIN, 32'hFFFF_FFFF, 32'h1, 32'h2, 5'd0}, 1'b1,
			'{STAT_OK, KIND_BEGIN, 32'hFFFF_FFFF, 32'h1, 32'h2, 5'd3, 6'd4}},
		'{1'b0, '{OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 5'd0}, 1'b1,
			'{STAT_OK, KIND_BEGIN, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			5'd3, 6'd4}},
		'{1'b0, '{OP_MOVE, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 5'd0}, 1'b0, '0},
		'{1'b0, '{OP_CANCEL, 32'hFFFF_FFFF, 32'h0, 32'h0, 5'd0}, 1'b0, '0},
		'{1'b0, '{OP_READ_ACTIVE, 32'h0, 32'h0, 32'h0, 5'd0}, 1'b0, '0},
		'{1'b0, '{OP_READ_HIST, 32'h0, 32'h0, 32'h0, 5'd0}, 1'b0, '0},
		'{1'b0, '{OP_END, 32'h0, 32'h1234_5678, 32'h9ABC_DEF0, 5'd0}, 1'b0, '0},
		'{1'b0, '{OP_END, 32'h1234_5678, 32'h0, 32'h0, 5'd0}, 1'b0, '0},
		'{1'b0, '{OP_RESET, 32'h1357_9BDF, 32'h2468_ACE0, 32'h0F0F_0F0F, 5'd31}, 1'b1,
			'{STAT_OK, KIND_BEGIN, 32'h0, 32'h0, 32'h0, 5'd1, 6'd0}},
		'{1'b0, '{OP_READ_HIST, 32'h0, 32'h0, 32'h0, 5'd0}, 1'b1,
			'{STAT_RANGE, KIND_BEGIN, 32'h0, 32'h0, 32'h0, 5'd1, 6'd0}},
		'{1'b1, '{OP_BEGIN, 32'hA5A5_A5A5, 32'h0003_8000, 32'hFFFD_4000, 5'd0}, 1'b0, '0},
		'{1'b1, '{OP_MOVE, 32'hA5A5_A5A5, 32'h7FFF_FFFF, 32'h8000_0000, 5'd0}, 1'b0, '0},
		'{1'b1, '{OP_MOVE, 32'h5A5A_5A5A, 32'h8000_0000, 32'h7FFF_FFFF, 5'd0}, 1'b0, '0},
		'{1'b1, '{OP_END, 32'hA5A5_A5A5, 32'h0, 32'h0, 5'd0}, 1'b0, '0},
		'{1'b1, '{OP_CANCEL, 32'hFFFF_FFFF, 32'h0, 32'h0, 5'd0}, 1'b0, '0},
		'{1'b1, '{OP_READ_HIST, 32'h0, 32'h0, 32'h0, 5'd0}, 1'b0, '0},
		'{1'b1, '{OP_READ_ACTIVE, 32'h0, 32'h0, 32'h0, 5'd2}, 1'b0, '0},
		'{1'b1, '{OP_RESET, 32'h0, 32'h0, 32'h0, 5'd0}, 1'b0, '0},
		'{1'b0, '{OP_READ_ACTIVE, 32'h0, 32'h0, 32'h0, 5'd0}, 1'b0, '0}
	};

	touch_contact_tracker #(
		.MAX_CONTACTS (MAX_CONTACTS),
		.HISTORY_DEPTH(HIST_DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #6 clk = ~clk;

	function automatic int find_contact(logic [31:0] id);
		int i;
		for (i = 0; i < trk_total; i++) begin
			if (trk_id[i] == id) begin
				return i;
			end
		end
		return trk_total;
	endfunction

	function automatic bit add_contact(logic [31:0] id, logic [31:0] x, logic [31:0] y);
		if (trk_total >= MAX_CONTACTS) begin
			return 1'b0;
		end
		trk_id[trk_total] = id;
		trk_x[trk_total] = x;
		trk_y[trk_total] = y;
		trk_total++;
		return 1'b1;
	endfunction

	function automatic result_t apply_touch_op(touch_item_t it);
		result_t r;
		int      pos;
		int      i;
		r = '0;
		r.status = STAT_OK;
		r.event_kind = KIND_BEGIN;
		case (it.op)
			OP_BEGIN, OP_MOVE, OP_END, OP_CANCEL: begin
				r.out_id = it.id;
				r.out_x = it.x;
				r.out_y = it.y;
				if (!imm_mode) begin
					case (it.op)
						OP_BEGIN: r.event_kind = KIND_BEGIN;
						OP_MOVE: r.event_kind = KIND_MOVE;
						default: r.event_kind = KIND_END;
					endcase
					if (hist_total >= HIST_DEPTH) begin
						for (i = 0; i < HIST_DEPTH - 1; i++) begin
							hist_kind[i] = hist_kind[i + 1];
							hist_id[i] = hist_id[i + 1];
							hist_x[i] = hist_x[i + 1];
							hist_y[i] = hist_y[i + 1];
						end
						hist_total = HIST_DEPTH - 1;
					end
					hist_kind[hist_total] = r.event_kind;
					hist_id[hist_total] = it.id;
					hist_x[hist_total] = it.x;
					hist_y[hist_total] = it.y;
					hist_total++;
					if (it.op == OP_BEGIN) begin
						if (!add_contact(it.id, it.x, it.y)) begin
							r.status = STAT_FULL;
						end
					end else begin
						pos = find_contact(it.id);
						if (pos >= trk_total) begin
							r.status = STAT_NOT_FOUND;
						end else if (it.op == OP_MOVE) begin
							trk_x[pos] = it.x;
							trk_y[pos] = it.y;
						end else begin
							for (i = pos; i + 1 < trk_total; i++) begin
								trk_id[i] = trk_id[i + 1];
								trk_x[i] = trk_x[i + 1];
								trk_y[i] = trk_y[i + 1];
							end
							trk_total--;
						end
					end
				end else if (it.op == OP_BEGIN || it.op == OP_MOVE) begin
					pos = find_contact(it.id);
					if (pos < trk_total) begin
						trk_x[pos] = it.x;
						trk_y[pos] = it.y;
					end else if (!add_contact(it.id, it.x, it.y)) begin
						r.status = STAT_FULL;
					end
				end
			end
			OP_RESET: begin
				if (imm_mode) begin
					trk_total = 0;
				end else begin
					hist_total = 0;
				end
			end
			OP_LOOKUP: begin
				pos = find_contact(it.id);
				if (pos < trk_total) begin
					r.out_id = trk_id[pos];
					r.out_x = trk_x[pos];
					r.out_y = trk_y[pos];
				end else begin
					r.status = STAT_NOT_FOUND;
				end
			end
			OP_READ_HIST: begin
				if (it.idx < hist_total) begin
					r.event_kind = hist_kind[it.idx];
					r.out_id = hist_id[it.idx];
					r.out_x = hist_x[it.idx];
					r.out_y = hist_y[it.idx];
				end else begin
					r.status = STAT_RANGE;
				end
			end
			default: begin
				if (it.idx < trk_total) begin
					r.out_id = trk_id[it.idx];
					r.out_x = trk_x[it.idx];
					r.out_y = trk_y[it.idx];
				end else begin
					r.status = STAT_RANGE;
				end
			end
		endcase
		r.active_count = 5'(trk_total);
		r.history_count = 6'(hist_total);
		return r;
	endfunction

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (bad_fields < 100) begin
			$display("MISMATCH result %0d %s: got %h, want %h", reply_count, what, got, want);
		end
		bad_fields++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch(what, got, want);
		end
	endtask

	task automatic push_item(input touch_item_t it, input bit typed, input result_t want);
		result_t pred;
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {it.idx, it.y, it.x, it.id, it.op};
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		pred = apply_touch_op(it);
		tracker_replies = {tracker_replies, typed ? want : pred};
	endtask

	task automatic drain_block();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (tracker_replies.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_mode(input bit mode);
		drain_block();
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we <= 1'b0;
		imm_mode = mode;
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (tracker_replies.size() == 0) begin
				report_mismatch("unexpected transfer", m_axis_tdata[35:4], 32'h0);
			end else begin
				want_reply = tracker_replies.pop_front();
				got_reply.status = status_t'(m_axis_tdata[1:0]);
				got_reply.event_kind = kind_t'(m_axis_tdata[3:2]);
				got_reply.out_id = m_axis_tdata[35:4];
				got_reply.out_x = m_axis_tdata[67:36];
				got_reply.out_y = m_axis_tdata[99:68];
				got_reply.active_count = m_axis_tdata[104:100];
				got_reply.history_count = m_axis_tdata[110:105];
				check_field("status", got_reply.status, want_reply.status);
				check_field("event_kind", got_reply.event_kind, want_reply.event_kind);
				check_field("out_id", got_reply.out_id, want_reply.out_id);
				check_field("out_x", got_reply.out_x, want_reply.out_x);
				check_field("out_y", got_reply.out_y, want_reply.out_y);
				check_field("active_count", got_reply.active_count,
					want_reply.active_count);
				check_field("history_count", got_reply.history_count,
					want_reply.history_count);
			end
			reply_count++;
		end
	end

	initial begin
		#(LIMIT_CYCLES * 12);
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		touch_item_t item;
		int          sel;
		int          seg;
		int          n;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_idle = 34;
		recv_idle = 61;
		for (int r = 0; r < NUM_DIR; r++) begin
			if (dir_rows[r].mode != imm_mode) begin
				write_mode(dir_rows[r].mode);
			end
			push_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
		end
		for (seg = 0; seg < NUM_SEGS; seg++) begin
			case (seg / 2)
				0: begin
					send_idle = 34;
					recv_idle = 61;
				end
				1: begin
					send_idle = 61;
					recv_idle = 34;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			write_mode(seg[0]);
			for (n = 0; n < SEG_ITEMS; n++) begin
				if (n == 100 && (seg == 0 || seg == 4)) begin
					hold_req++;
				end
				sel = $urandom_range(99);
				if (sel < 28) begin
					item.op = OP_BEGIN;
				end else if (sel < 50) begin
					item.op = OP_MOVE;
				end else if (sel < 62) begin
					item.op = OP_END;
				end else if (sel < 70) begin
					item.op = OP_CANCEL;
				end else if (sel < 73) begin
					item.op = OP_RESET;
				end else if (sel < 82) begin
					item.op = OP_LOOKUP;
				end else if (sel < 91) begin
					item.op = OP_READ_HIST;
				end else begin
					item.op = OP_READ_ACTIVE;
				end
				if (trk_total > 0 &&
						$urandom_range(99) < ((item.op == OP_BEGIN) ? 20 : 75)) begin
					item.id = trk_id[$urandom_range(trk_total - 1)];
				end else if ($urandom_range(9) == 0) begin
					item.id = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
				end else begin
					item.id = $urandom;
				end
				item.x = pick_coord();
				item.y = pick_coord();
				item.idx = $urandom_range(1) ? 5'($urandom_range(31)) : 5'($urandom_range(15));
				push_item(item, 1'b0, '0);
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (tracker_replies.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE) @(negedge clk);
		if (bad_fields == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
